// ===== rtl/psu_pkg.sv =====
// Shared types and constants of the PNG scanline unfilter block.
`timescale 1ns / 1ps
`default_nettype none
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ROW_W  = 14;                       // row_bytes register width
  localparam int BPP_W  = 4;                        // bytes_per_pixel register width
  localparam int COL_W  = $clog2(MAX_ROW_BYTES);    // line store address width
  localparam int WIN_W  = $clog2(MAX_PIXEL_BYTES);  // window index width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd1;

  localparam logic [7:0] MAX_FILTER_CODE = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_item_t;

  // Operands handed to the predictor
  typedef struct packed {
    logic [7:0] filt_byte;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] up_left;
    logic [2:0] kind;
    logic       err;
  } pred_in_t;

endpackage
`default_nettype wire

// ===== rtl/psu_predict.sv =====
// Predictor and byte reconstruction for the five PNG filter types.
`timescale 1ns / 1ps
`default_nettype none
module psu_predict (
  input  psu_pkg::pred_in_t   p,
  output logic [7:0]          raw
);
  import psu_pkg::*;

  logic signed [9:0] pa;
  logic signed [9:0] pb;
  logic signed [9:0] pc;
  logic signed [9:0] da;
  logic signed [9:0] db;
  logic signed [9:0] dc;
  logic [8:0]        avg_sum;
  logic [7:0]        paeth;
  logic [7:0]        pred;

  always_comb begin
    da = $signed({2'b00, p.up}) - $signed({2'b00, p.up_left});
    db = $signed({2'b00, p.left}) - $signed({2'b00, p.up_left});
    dc = da + db;
    pa = da[9] ? -da : da;
    pb = db[9] ? -db : db;
    pc = dc[9] ? -dc : dc;
    // ties go to left, then up, then upper-left
    priority if (pa <= pb && pa <= pc) begin
      paeth = p.left;
    end else if (pb <= pc) begin
      paeth = p.up;
    end else begin
      paeth = p.up_left;
    end
  end

  assign avg_sum = {1'b0, p.left} + {1'b0, p.up};

  always_comb begin
    pred = 8'd0;
    if (!p.err) begin
      unique case (p.kind)
        FILT_SUB:   pred = p.left;
        FILT_UP:    pred = p.up;
        FILT_AVG:   pred = avg_sum[8:1];
        FILT_PAETH: pred = paeth;
        default:    pred = 8'd0;
      endcase
    end
  end

  assign raw = p.filt_byte + pred;

endmodule
`default_nettype wire

// ===== rtl/png_scanline_unfilter.sv =====
// PNG scanline unfilter: filter-type decode, line store and byte reconstruction.
//
// Usage:
//   in_*  : one byte of the inflated stream per item. A row starts with its
//           filter-type byte, then row_bytes data bytes. Set image_start on the
//           filter byte of the first row of an image (it also aborts a row).
//   out_* : one reconstructed byte per data byte, row_end on the last byte of
//           a row. An unknown filter type yields one marker item (pixel 0,
//           bad_filter 1); that row's bytes then pass through with bad_filter.
//   cfg_* : row_bytes (index 0) and bytes_per_pixel (index 1); write only while
//           the block is idle. cfg_ready is always high.
// Timing: one item per cycle sustained while out_stall is low. Stage 1
//   decodes the row position and issues the line store read; stage 2
//   reconstructs the byte with the read data and writes it back; the output
//   register follows, so a result passes stage 2 and the output register
//   before it shows on out_*. The single-port-per-direction line store
//   (one read, one write a cycle) sets the one-item-per-cycle rate.
// Reset: rst_n (synchronous, active low) returns to waiting for a filter byte
//   of a first row; the line store is not cleared and holds no valid data.
// Stall: while out_stall holds a result, stage 2 keeps an item that needs the
//   output, and in_stall rises only while stage 2 holds an item that needs the
//   output and the output register holds a stalled result.
`timescale 1ns / 1ps
`default_nettype none
module png_scanline_unfilter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  psu_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output psu_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psu_pkg::*;

  // configuration
  logic [ROW_W-1:0] row_bytes_r;
  logic [BPP_W-1:0] bpp_r;
  logic [ROW_W-1:0] len;
  logic [BPP_W-1:0] bpp;
  logic [WIN_W-1:0] bpp_idx;

  // stage 1 row tracking
  logic [COL_W-1:0] column_r;
  logic             expect_filter_r;
  logic             first_row_r;
  logic [2:0]       filter_kind_r;
  logic             row_error_r;

  logic             in_accept;
  logic             take_filter;
  logic             hdr_err;
  logic [ROW_W-1:0] col_inc;
  logic             last;
  logic             use_a;

  // stage 2
  logic             s2_valid_r;
  logic             s2_filter_r;
  logic             s2_err_r;
  logic [7:0]       s2_byte_r;
  logic [COL_W-1:0] s2_x_r;
  logic             s2_use_a_r;
  logic             s2_first_r;
  logic [2:0]       s2_kind_r;
  logic             s2_last_r;
  logic             s2_has_out;
  logic             s2_adv;
  logic             s2_go;

  logic [7:0]       line_mem [MAX_ROW_BYTES];
  logic [7:0]       rd_r;
  logic             mem_we;

  logic [7:0]       left_r [MAX_PIXEL_BYTES];
  logic [7:0]       ul_r   [MAX_PIXEL_BYTES];

  pred_in_t         pin;
  logic [7:0]       raw;

  logic             out_valid_r;
  out_item_t        out_item_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_W'(1);
      bpp_r       <= BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_BYTES:       row_bytes_r <= cfg_data[ROW_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_r       <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp register values to the legal range: zero acts as one.
  always_comb begin
    len = row_bytes_r;
    if (len == '0) len = ROW_W'(1);
    if (len > ROW_W'(MAX_ROW_BYTES)) len = ROW_W'(MAX_ROW_BYTES);
    bpp = bpp_r;
    if (bpp == '0) bpp = BPP_W'(1);
    if (bpp > BPP_W'(MAX_PIXEL_BYTES)) bpp = BPP_W'(MAX_PIXEL_BYTES);
  end

  assign bpp_idx = WIN_W'(bpp - BPP_W'(1));

  // ---------------- stage 1: row position ----------------
  assign in_accept   = in_valid && !in_stall;
  assign take_filter = in_item.image_start || expect_filter_r;
  assign hdr_err     = in_item.data_byte > MAX_FILTER_CODE;
  assign col_inc     = ROW_W'(column_r) + ROW_W'(1);
  assign last        = col_inc >= len;
  assign use_a       = column_r >= COL_W'(bpp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r        <= '0;
      expect_filter_r <= 1'b1;
      first_row_r     <= 1'b1;
      filter_kind_r   <= FILT_NONE;
      row_error_r     <= 1'b0;
    end else if (in_accept) begin
      if (take_filter) begin
        // open a new row; image_start abandons whatever row was in progress
        if (in_item.image_start) first_row_r <= 1'b1;
        expect_filter_r <= 1'b0;
        column_r        <= '0;
        filter_kind_r   <= in_item.data_byte[2:0];
        row_error_r     <= hdr_err;
      end else if (last) begin
        column_r        <= '0;
        expect_filter_r <= 1'b1;
        first_row_r     <= 1'b0;
      end else begin
        column_r        <= col_inc[COL_W-1:0];
      end
    end
  end

  // Line store read for the byte above. A write to column x happens after its
  // own read, as its item leaves stage 2; the next read of x needs a filter byte
  // in between, so a read never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_r <= line_mem[column_r];
    end
    if (mem_we) begin
      line_mem[s2_x_r] <= raw;
    end
  end

  // Hand the decoded item to stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_accept) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s2_filter_r <= take_filter;
      s2_err_r    <= take_filter ? hdr_err : row_error_r;
      s2_byte_r   <= in_item.data_byte;
      s2_x_r      <= column_r;
      s2_use_a_r  <= use_a;
      s2_first_r  <= first_row_r;
      s2_kind_r   <= filter_kind_r;
      s2_last_r   <= last;
    end
  end

  // ---------------- stage 2: reconstruct ----------------
  assign s2_has_out = s2_filter_r ? s2_err_r : 1'b1;
  assign s2_adv     = !s2_has_out || !out_valid_r || !out_stall;
  assign s2_go      = s2_valid_r && s2_adv;
  assign in_stall   = s2_valid_r && !s2_adv;
  assign mem_we     = s2_go && !s2_filter_r;

  always_comb begin
    pin.filt_byte = s2_byte_r;
    pin.left      = s2_use_a_r ? left_r[bpp_idx] : 8'd0;
    pin.up        = s2_first_r ? 8'd0 : rd_r;
    pin.up_left   = (s2_use_a_r && !s2_first_r) ? ul_r[bpp_idx] : 8'd0;
    pin.kind      = s2_kind_r;
    pin.err       = s2_err_r;
  end

  psu_predict u_predict (
    .p   (pin),
    .raw (raw)
  );

  // Neighbor windows: clear on a filter byte, shift on each data byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= 8'd0;
        ul_r[i]   <= 8'd0;
      end
    end else if (s2_go) begin
      if (s2_filter_r) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_r[i] <= 8'd0;
          ul_r[i]   <= 8'd0;
        end
      end else begin
        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
          left_r[i] <= left_r[i-1];
          ul_r[i]   <= ul_r[i-1];
        end
        left_r[0] <= raw;
        ul_r[0]   <= pin.up;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && s2_has_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_has_out) begin
      if (s2_filter_r) begin
        // error marker for an unknown filter type
        out_item_r.pixel_byte <= 8'd0;
        out_item_r.row_end    <= 1'b0;
        out_item_r.bad_filter <= 1'b1;
      end else begin
        out_item_r.pixel_byte <= raw;
        out_item_r.row_end    <= s2_last_r;
        out_item_r.bad_filter <= s2_err_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // An empty stage 2 never holds off the input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_valid_r |-> !in_stall)
    else $error("input stalled with stage 2 empty");

  // The line store is written only by data bytes
  a_we_data_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (s2_valid_r && !s2_filter_r))
    else $error("line store written by a filter byte");

  // The first byte of a row has no left neighbor
  a_col0_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_filter_r && s2_x_r == '0) |-> !s2_use_a_r)
    else $error("left neighbor used at column zero");

  // After the last data byte of a row the next item is a filter byte
  a_row_end_expect: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !take_filter && last) |=> (expect_filter_r && column_r == '0))
    else $error("row end did not rearm filter byte decode");
`endif

endmodule
`default_nettype wire
